/* src/tkl_pkg.sv */
// Shared types and constants of the bounded top-k keyed list.
`timescale 1ns / 1ps

package tkl_pkg;

	localparam int KEY_W  = 32;
	localparam int FREQ_W = 16;
	localparam int POS_W  = 3;
	localparam int CNT_W  = 4;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_READ   = 2'd2,
		KIND_LOOKUP = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [KEY_W-1:0]    word_key;
		logic [FREQ_W-1:0]   frequency;
		logic [POS_W-1:0]    position;
	} cmd_word_t;

	typedef struct packed {
		logic                accepted;
		logic                found;
		logic [POS_W-1:0]    found_position;
		logic                entry_valid;
		logic [KEY_W-1:0]    entry_key;
		logic [FREQ_W-1:0]   entry_freq;
		logic [CNT_W-1:0]    count;
	} res_word_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		logic                add_do;
		logic                clear;
		logic [KEY_W-1:0]    key;
		logic [FREQ_W-1:0]   freq;
	} bcast_t;

	// Passed from each cell to the next one down the list.
	typedef struct packed {
		logic                valid;
		logic                ge;
		logic                hit_above;
		logic [KEY_W-1:0]    key;
		logic [FREQ_W-1:0]   freq;
	} link_t;

	// Per-cell status seen by the control.
	typedef struct packed {
		logic                match;
		logic                stale;
	} cell_stat_t;

endpackage

/* src/tkl_cell.sv */
// One list position: holds an entry, compares it and shifts it down on insertion.
`timescale 1ns / 1ps

module tkl_cell
	import tkl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  bcast_t     bcast,
	input  link_t      prev,
	output link_t      next,
	output cell_stat_t stat
);

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [FREQ_W-1:0] freq_q;
	logic              ge;
	logic              match;
	logic              in_range;
	logic              insert;
	logic              shift;

	assign ge       = valid_q & (freq_q >= bcast.freq);
	assign match    = valid_q & (key_q == bcast.key);
	// This cell lies at or above the slot that the add frees or fills.
	assign in_range = prev.valid & ~prev.hit_above;
	assign insert   = bcast.add_do & in_range & ~ge & prev.ge;
	assign shift    = bcast.add_do & in_range & ~prev.ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bcast.clear) begin
			valid_q <= 1'b0;
		end else if (insert | shift) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			key_q  <= bcast.key;
			freq_q <= bcast.freq;
		end else if (shift) begin
			key_q  <= prev.key;
			freq_q <= prev.freq;
		end
	end

	assign next.valid     = valid_q;
	assign next.ge        = ge;
	assign next.hit_above = prev.hit_above | match;
	assign next.key       = key_q;
	assign next.freq      = freq_q;

	assign stat.match = match;
	assign stat.stale = match & (freq_q < bcast.freq);

endmodule

/* src/top_k_keyed_list_core.sv */
// Top level of the bounded top-k keyed list: cell row, control and result register.
// A result is registered when its word is accepted.
// Throughput: one word per cycle while results are taken; cmd_ready drops only
// while a finished result waits on res_ready.
// The cycle is set by the per-cell key and frequency compares and the match ripple.
// Reset empties the list and drops any pending result; stored entries are not cleared.
`timescale 1ns / 1ps

module top_k_keyed_list_core
	import tkl_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_word_t cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res
);

	localparam int OCC_W = $clog2(CAPACITY + 1);

	bcast_t                bcast;
	link_t                 links [CAPACITY+1];
	cell_stat_t            stats [CAPACITY];
	logic [CAPACITY-1:0]   match_vec;
	logic [CAPACITY-1:0]   valid_vec;
	logic [OCC_W-1:0]      count_q;
	logic [OCC_W-1:0]      count_next;
	logic                  cmd_fire;
	logic                  hit;
	logic                  stale_any;
	logic                  full;
	logic                  last_lt;
	logic                  add_ok;
	logic                  res_valid_q;
	res_word_t             res_q;
	res_word_t             res_d;

	assign cmd_fire  = cmd_valid & cmd_ready;
	assign cmd_ready = ~res_valid_q | res_ready;

	assign links[0] = '{valid: 1'b1, ge: 1'b1, hit_above: 1'b0, key: '0, freq: '0};

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		tkl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bcast  (bcast),
			.prev   (links[g]),
			.next   (links[g+1]),
			.stat   (stats[g])
		);
		assign match_vec[g] = stats[g].match;
		assign valid_vec[g] = links[g+1].valid;
	end

	always_comb begin
		stale_any = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			stale_any = stale_any | stats[i].stale;
		end
	end

	assign hit     = |match_vec;
	assign full    = (count_q == OCC_W'(CAPACITY));
	assign last_lt = links[CAPACITY].valid & ~links[CAPACITY].ge;
	assign add_ok  = hit ? stale_any : (~full | last_lt);

	assign bcast.add_do = cmd_fire & (cmd.kind == KIND_ADD) & add_ok;
	assign bcast.clear  = cmd_fire & (cmd.kind == KIND_CLEAR);
	assign bcast.key    = cmd.word_key;
	assign bcast.freq   = cmd.frequency;

	always_comb begin
		count_next = count_q;
		case (cmd.kind)
			KIND_ADD: begin
				if (add_ok && !hit && !full) begin
					count_next = count_q + OCC_W'(1);
				end
			end
			KIND_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	always_comb begin
		res_d       = '0;
		res_d.count = CNT_W'(count_next);
		case (cmd.kind)
			KIND_ADD: begin
				res_d.accepted = add_ok;
			end
			KIND_READ: begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (int'(cmd.position) == i && links[i+1].valid) begin
						res_d.entry_valid = 1'b1;
						res_d.entry_key   = links[i+1].key;
						res_d.entry_freq  = links[i+1].freq;
					end
				end
			end
			KIND_LOOKUP: begin
				res_d.found = hit;
				for (int i = 0; i < CAPACITY; i++) begin
					if (match_vec[i]) begin
						res_d.found_position = POS_W'(i);
					end
				end
			end
			default: begin
				res_d.count = CNT_W'(count_next);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_fire) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OCC_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("key held in more than one cell");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		bcast.clear |=> (count_q == '0) && (valid_vec == '0))
		else $error("list not empty after clear");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bounded top-k keyed list core.
`timescale 1ns / 1ps

module testbench;
	import tkl_pkg::*;

	localparam int LIST_DEPTH = 8;
	localparam int STALL_LIMIT = 1000;
	localparam int REPORT_MAX = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_word_t res;

	logic [KEY_W-1:0]  list_keys [LIST_DEPTH];
	logic [FREQ_W-1:0] list_freqs [LIST_DEPTH];
	int                list_len = 0;
	res_word_t         pending_results [$];
	logic [KEY_W-1:0]  key_pool [12];

	int error_count = 0;
	int quiet_cycles = 0;
	int ready_left = 0;
	bit sender_idle = 1'b1;
	bit receiver_stall = 1'b1;

	top_k_keyed_list_core #(
		.CAPACITY(LIST_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void float_up(input int idx);
		logic [KEY_W-1:0]  k;
		logic [FREQ_W-1:0] f;
		while (idx > 0 && list_freqs[idx-1] < list_freqs[idx]) begin
			k = list_keys[idx-1];
			f = list_freqs[idx-1];
			list_keys[idx-1] = list_keys[idx];
			list_freqs[idx-1] = list_freqs[idx];
			list_keys[idx] = k;
			list_freqs[idx] = f;
			idx--;
		end
	endfunction

	function automatic int find_slot(input logic [KEY_W-1:0] key);
		int hit;
		hit = -1;
		for (int n = 0; n < list_len; n++) begin
			if (hit < 0 && list_keys[n] == key)
				hit = n;
		end
		return hit;
	endfunction

	function automatic res_word_t step_list(input cmd_word_t c);
		res_word_t r;
		int        slot;
		r = '0;
		case (c.kind)
			KIND_ADD: begin
				slot = find_slot(c.word_key);
				if (slot >= 0) begin
					if (list_freqs[slot] < c.frequency) begin
						list_freqs[slot] = c.frequency;
						float_up(slot);
						r.accepted = 1'b1;
					end
				end else if (list_len < LIST_DEPTH) begin
					list_keys[list_len] = c.word_key;
					list_freqs[list_len] = c.frequency;
					list_len++;
					float_up(list_len - 1);
					r.accepted = 1'b1;
				end else if (list_freqs[LIST_DEPTH-1] < c.frequency) begin
					list_keys[LIST_DEPTH-1] = c.word_key;
					list_freqs[LIST_DEPTH-1] = c.frequency;
					float_up(LIST_DEPTH - 1);
					r.accepted = 1'b1;
				end
			end
			KIND_CLEAR: begin
				list_len = 0;
			end
			KIND_READ: begin
				if (c.position < list_len) begin
					r.entry_valid = 1'b1;
					r.entry_key = list_keys[c.position];
					r.entry_freq = list_freqs[c.position];
				end
			end
			default: begin
				slot = find_slot(c.word_key);
				if (slot >= 0) begin
					r.found = 1'b1;
					r.found_position = slot[POS_W-1:0];
				end
			end
		endcase
		r.count = list_len[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		res_word_t want;
		if (cmd_valid && cmd_ready)
			pending_results.push_back(step_list(cmd));
		if (res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("unexpected result word at %0t: %p", $realtime, res);
			end else begin
				want = pending_results.pop_front();
				if (res.accepted !== want.accepted || res.found !== want.found
						|| res.found_position !== want.found_position
						|| res.entry_valid !== want.entry_valid
						|| res.entry_key !== want.entry_key
						|| res.entry_freq !== want.entry_freq
						|| res.count !== want.count) begin
					error_count++;
					if (error_count <= REPORT_MAX) begin
						$display("mismatch at %0t", $realtime);
						$display("  expected acc=%0d fnd=%0d fpos=%0d vld=%0d key=%h freq=%h cnt=%0d",
							want.accepted, want.found, want.found_position, want.entry_valid,
							want.entry_key, want.entry_freq, want.count);
						$display("  actual   acc=%0d fnd=%0d fpos=%0d vld=%0d key=%h freq=%h cnt=%0d",
							res.accepted, res.found, res.found_position, res.entry_valid,
							res.entry_key, res.entry_freq, res.count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : receiver
		int r;
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (!receiver_stall || r < 55) begin
				res_ready <= 1'b1;
				ready_left <= $urandom_range(0, 6);
			end else if (r < 92) begin
				res_ready <= 1'b0;
				ready_left <= $urandom_range(0, 2);
			end else begin
				res_ready <= 1'b0;
				ready_left <= $urandom_range(8, 30);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d results outstanding", pending_results.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (!sender_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic cmd_word_t make_word(input kind_t k, input logic [KEY_W-1:0] key,
			input logic [FREQ_W-1:0] freq, input logic [POS_W-1:0] pos);
		cmd_word_t w;
		w.kind = k;
		w.word_key = key;
		w.frequency = freq;
		w.position = pos;
		return w;
	endfunction

	task automatic send_word(input cmd_word_t w);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do
			@(posedge clk);
		while (!cmd_ready);
	endtask

	function automatic void refill_key_pool();
		for (int n = 0; n < 12; n++)
			key_pool[n] = $urandom();
		key_pool[0] = '0;
		key_pool[1] = '1;
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t         w;
		int                r;
		int                fr;
		logic [FREQ_W-1:0] freq;
		logic [KEY_W-1:0]  key;
		r = $urandom_range(0, 99);
		fr = $urandom_range(0, 99);
		if (fr < 50)
			freq = FREQ_W'($urandom_range(0, 15));
		else if (fr < 80)
			freq = FREQ_W'($urandom());
		else
			freq = fr[0] ? '1 : '0;
		if ($urandom_range(0, 9) == 0)
			key = $urandom();
		else
			key = key_pool[$urandom_range(0, 11)];
		if (r < 55)
			w = make_word(KIND_ADD, key, freq, POS_W'($urandom()));
		else if (r < 75)
			w = make_word(KIND_READ, $urandom(), freq, POS_W'($urandom()));
		else if (r < 97)
			w = make_word(KIND_LOOKUP, key, freq, POS_W'($urandom()));
		else
			w = make_word(KIND_CLEAR, $urandom(), freq, POS_W'($urandom()));
		return w;
	endfunction

	task automatic test_directed();
		send_word(make_word(KIND_READ, 32'h0, 16'h0, 3'd0));
		send_word(make_word(KIND_LOOKUP, 32'h0, 16'h0, 3'd0));
		send_word(make_word(KIND_ADD, 32'h0, 16'h0, 3'd0));
		send_word(make_word(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 3'd7));
		send_word(make_word(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, 3'd0));
		send_word(make_word(KIND_ADD, 32'h0, 16'h0, 3'd0));
		send_word(make_word(KIND_ADD, 32'h0, 16'd5, 3'd0));
		send_word(make_word(KIND_ADD, 32'h11, 16'd5, 3'd0));
		send_word(make_word(KIND_ADD, 32'h12, 16'd5, 3'd0));
		send_word(make_word(KIND_ADD, 32'h13, 16'd100, 3'd0));
		send_word(make_word(KIND_ADD, 32'h14, 16'd3, 3'd0));
		send_word(make_word(KIND_ADD, 32'h15, 16'd1, 3'd0));
		send_word(make_word(KIND_ADD, 32'h16, 16'd1, 3'd0));
		send_word(make_word(KIND_ADD, 32'h17, 16'd1, 3'd0));
		send_word(make_word(KIND_ADD, 32'h18, 16'd2, 3'd0));
		send_word(make_word(KIND_READ, 32'h0, 16'h0, 3'd0));
		send_word(make_word(KIND_READ, 32'h0, 16'h0, 3'd3));
		send_word(make_word(KIND_READ, 32'h0, 16'h0, 3'd7));
		send_word(make_word(KIND_LOOKUP, 32'h13, 16'h0, 3'd0));
		send_word(make_word(KIND_LOOKUP, 32'hDEAD, 16'h0, 3'd0));
		send_word(make_word(KIND_CLEAR, 32'h0, 16'h0, 3'd0));
		send_word(make_word(KIND_READ, 32'h0, 16'h0, 3'd0));
		send_word(make_word(KIND_LOOKUP, 32'h13, 16'h0, 3'd0));
	endtask

	task automatic test_random_traffic(input int n, input bit with_idle);
		sender_idle = with_idle;
		receiver_stall = with_idle;
		refill_key_pool();
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 149)
				refill_key_pool();
			send_word(random_word());
		end
	endtask

	task automatic test_drain_pause();
		sender_idle = 1'b0;
		receiver_stall = 1'b1;
		for (int i = 0; i < 20; i++)
			send_word(random_word());
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		for (int i = 0; i < 20; i++)
			send_word(random_word());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(400, 1'b1);
		test_drain_pause();
		test_random_traffic(300, 1'b0);
		test_random_traffic(300, 1'b1);
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
